// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL files that check their own logic.
// Each use stands on a line of its own and needs no trailing semicolon.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/nctt_pkg.sv =====
package nctt_pkg;

    // Table geometry
    localparam int MAX_CONTACTS = 16;
    localparam int ID_WIDTH     = 16;
    localparam int IDX_W        = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;
    localparam int USED_W       = $clog2(MAX_CONTACTS + 1);

    // Fixed field widths of the words on the ports
    localparam int IN_ID_W  = 16;
    localparam int SLOT_W   = 4;
    localparam int UNIQ_W   = 5;
    localparam int TOTAL_W  = 16;
    localparam int COUNT_W  = 8;

    // Item kinds
    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    typedef logic [ID_WIDTH-1:0] id_t;
    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [USED_W-1:0]   used_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [TOTAL_W-1:0]  total_t;

    localparam count_t COUNT_MAX = '1;
    localparam total_t TOTAL_MAX = '1;

    typedef struct packed {
        idx_t   slot;
        logic   is_new;
        logic   table_full;
        used_t  unique_count;
        total_t total_contacts;
        count_t peak_count;
    } result_t;

    typedef struct packed {
        logic  busy;
        used_t entries_used;
    } seq_status_t;

    typedef struct packed {
        logic   we;
        idx_t   addr;
        id_t    id;
        count_t count;
    } store_wr_t;

endpackage

// ===== rtl/core/nctt_in_if.sv =====
interface nctt_in_if import nctt_pkg::*; ();

    logic               valid;
    logic               ready;
    logic               kind;
    logic [IN_ID_W-1:0] neighbour_id;

    modport source (output valid, output kind, output neighbour_id, input ready);
    modport sink   (input valid, input kind, input neighbour_id, output ready);

endinterface

// ===== rtl/core/nctt_out_if.sv =====
interface nctt_out_if import nctt_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [SLOT_W-1:0]  slot;
    logic               is_new;
    logic               table_full;
    logic [UNIQ_W-1:0]  unique_count;
    logic [TOTAL_W-1:0] total_contacts;
    logic [COUNT_W-1:0] peak_count;

    modport source (output valid, output slot, output is_new, output table_full,
                    output unique_count, output total_contacts, output peak_count,
                    input ready);
    modport sink   (input valid, input slot, input is_new, input table_full,
                    input unique_count, input total_contacts, input peak_count,
                    output ready);

endinterface

// ===== rtl/core/nctt_store.sv =====
module nctt_store import nctt_pkg::*;
(
    input  logic      clk,
    input  store_wr_t wr,
    input  idx_t      rd_addr,
    output id_t       rd_id,
    output count_t    rd_count
);

    id_t    ids_mem    [MAX_CONTACTS];
    count_t counts_mem [MAX_CONTACTS];
    id_t    rd_id_reg;
    count_t rd_count_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            ids_mem[wr.addr]    <= wr.id;
            counts_mem[wr.addr] <= wr.count;
        end
        rd_id_reg    <= ids_mem[rd_addr];
        rd_count_reg <= counts_mem[rd_addr];
    end

    assign rd_id    = rd_id_reg;
    assign rd_count = rd_count_reg;

endmodule

// ===== rtl/core/nctt_seq.sv =====
module nctt_seq import nctt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    nctt_in_if.sink     cmd,
    output result_t     res,
    output logic        res_valid,
    input  logic        res_ready,
    output seq_status_t status,
    output store_wr_t   wr,
    output idx_t        rd_addr,
    input  id_t         rd_id,
    input  count_t      rd_count
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_DONE
    } state_t;

    state_t state_reg;
    id_t    key_reg;
    idx_t   scan_reg;
    idx_t   slot_reg;
    count_t cnt_reg;
    logic   hit_reg;
    logic   is_new_reg;
    logic   full_reg;
    used_t  used_reg;
    total_t total_reg;
    count_t largest_reg;

    logic   table_full;
    logic   last_entry;
    logic   id_match;
    count_t new_count;

    assign table_full = (used_reg == used_t'(MAX_CONTACTS));
    assign last_entry = (used_t'(scan_reg) == used_reg - 1'b1);
    assign id_match   = (rd_id == key_reg);
    assign new_count  = hit_reg ? ((cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + 1'b1)
                                : count_t'(1);

    // Prefetch the next entry while the current one is compared
    assign rd_addr = (state_reg == S_SCAN) ? idx_t'(scan_reg + 1'b1) : '0;

    always_comb
    begin
        wr.we    = (state_reg == S_UPDATE) && (hit_reg || !table_full);
        wr.addr  = hit_reg ? slot_reg : idx_t'(used_reg);
        wr.id    = key_reg;
        wr.count = new_count;
    end

    assign cmd.ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb
    begin
        res.slot           = slot_reg;
        res.is_new         = is_new_reg;
        res.table_full     = full_reg;
        res.unique_count   = used_reg;
        res.total_contacts = total_reg;
        res.peak_count     = largest_reg;
    end

    assign status.busy         = (state_reg != S_IDLE);
    assign status.entries_used = used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            key_reg     <= '0;
            scan_reg    <= '0;
            slot_reg    <= '0;
            cnt_reg     <= '0;
            hit_reg     <= 1'b0;
            is_new_reg  <= 1'b0;
            full_reg    <= 1'b0;
            used_reg    <= '0;
            total_reg   <= '0;
            largest_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        slot_reg   <= '0;
                        is_new_reg <= 1'b0;
                        full_reg   <= 1'b0;
                        if (cmd.kind == KIND_CLEAR)
                        begin
                            used_reg    <= '0;
                            total_reg   <= '0;
                            largest_reg <= '0;
                            state_reg   <= S_DONE;
                        end
                        else
                        begin
                            key_reg  <= id_t'(cmd.neighbour_id);
                            scan_reg <= '0;
                            hit_reg  <= 1'b0;
                            if (total_reg != TOTAL_MAX)
                            begin
                                total_reg <= total_reg + 1'b1;
                            end
                            // Empty table: nothing to search, go append
                            state_reg <= (used_reg == '0) ? S_UPDATE : S_SCAN;
                        end
                    end
                end

                S_SCAN:
                begin
                    if (id_match)
                    begin
                        hit_reg   <= 1'b1;
                        slot_reg  <= scan_reg;
                        cnt_reg   <= rd_count;
                        state_reg <= S_UPDATE;
                    end
                    else if (last_entry)
                    begin
                        state_reg <= S_UPDATE;
                    end
                    else
                    begin
                        scan_reg <= idx_t'(scan_reg + 1'b1);
                    end
                end

                S_UPDATE:
                begin
                    if (hit_reg)
                    begin
                        if (new_count > largest_reg)
                        begin
                            largest_reg <= new_count;
                        end
                    end
                    else if (!table_full)
                    begin
                        slot_reg   <= idx_t'(used_reg);
                        is_new_reg <= 1'b1;
                        used_reg   <= used_reg + 1'b1;
                        if (new_count > largest_reg)
                        begin
                            largest_reg <= new_count;
                        end
                    end
                    else
                    begin
                        full_reg <= 1'b1;
                    end
                    state_reg <= S_DONE;
                end

                S_DONE:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/neighbour_contact_tally_table.sv =====
// Neighbour contact tally table. Each input word either records one contact
// with a neighbour identifier (kind add) or empties the table (kind clear),
// and each gives exactly one result word. An add searches the filled entries
// in order through the table's single read port, one entry per cycle, with
// one shared identifier comparator; a hit bumps that entry's count
// (saturating at 255), a miss appends the identifier with count one, and a
// miss on a full table drops the identifier and raises table_full with slot
// zero. Every add bumps the total contact counter (saturating at 65535); the
// result also carries the number of distinct neighbours held and the largest
// single-neighbour count. The sequencer holds one word at a time: an add
// takes the word, searches the filled entries up to the hit (at most the
// filled count, 16 with the default table), updates the entry and hands
// off the result; a clear goes straight to the hand-off, and an add on an
// empty table skips the search. Results land in an output register, so one
// waiting result does not block the next word from being searched. Table
// entries need no clearing after reset or clear: only entries below the
// fill count are ever compared.
module neighbour_contact_tally_table import nctt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    nctt_in_if.sink   cmd,
    nctt_out_if.source rsp
);

`include "assert_macros.svh"

    result_t     res;
    logic        res_valid;
    logic        res_ready;
    seq_status_t status;
    store_wr_t   wr;
    idx_t        rd_addr;
    id_t         rd_id;
    count_t      rd_count;

    // Output register
    logic               out_valid_reg;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic               out_is_new_reg;
    logic               out_full_reg;
    logic [UNIQ_W-1:0]  out_unique_reg;
    logic [TOTAL_W-1:0] out_total_reg;
    logic [COUNT_W-1:0] out_max_reg;

    nctt_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .status    (status),
        .wr        (wr),
        .rd_addr   (rd_addr),
        .rd_id     (rd_id),
        .rd_count  (rd_count)
    );

    nctt_store u_store
    (
        .clk      (clk),
        .wr       (wr),
        .rd_addr  (rd_addr),
        .rd_id    (rd_id),
        .rd_count (rd_count)
    );

    // Take a new result when the output register is empty or being drained
    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    // Payload: trim slot and unique count to the port widths
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_slot_reg   <= SLOT_W'(res.slot);
            out_is_new_reg <= res.is_new;
            out_full_reg   <= res.table_full;
            out_unique_reg <= UNIQ_W'(res.unique_count);
            out_total_reg  <= res.total_contacts;
            out_max_reg    <= res.peak_count;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.slot           = out_slot_reg;
    assign rsp.is_new         = out_is_new_reg;
    assign rsp.table_full     = out_full_reg;
    assign rsp.unique_count   = out_unique_reg;
    assign rsp.total_contacts = out_total_reg;
    assign rsp.peak_count     = out_max_reg;

    // A dropped identifier never claims a new slot
    `ASSERT_IMPLIES(a_full_not_new, clk, rst_n, rsp.valid && rsp.table_full, !rsp.is_new && (rsp.slot == '0))
    // Fill count never runs past the table depth
    `ASSERT_IMPLIES(a_fill_bound, clk, rst_n, 1'b1, status.entries_used <= USED_W'(MAX_CONTACTS))
    // A clear empties the table on the following cycle
    `ASSERT_NEXT(a_clear_empties, clk, rst_n, cmd.valid && cmd.ready && (cmd.kind == KIND_CLEAR), status.entries_used == '0)

endmodule

// ===== verif/neighbour_contact_tally_table_tb.sv =====
module neighbour_contact_tally_table_tb import nctt_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    // Random part size, saturation burst length and watchdog limit.
    // The burst repeats one identifier past 255 adds so that its pair count
    // pins at the ceiling.
    localparam int RANDOM_WORDS = 120;
    localparam int SAT_ADDS     = 260;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200_000;

    // ------------------------------------------------------------------
    // Tally scoreboard: mirrors the table, predicts one result per
    // accepted word and checks results against the oldest prediction.
    // ------------------------------------------------------------------
    class tally_scoreboard;
        id_t     ids    [MAX_CONTACTS];
        count_t  counts [MAX_CONTACTS];
        int      used;
        total_t  total;
        count_t  largest;
        result_t expected_q [$];
        int      mismatches;
        int      checked;
        int      appends;
        int      drops;
        int      clears;

        function new();
            wipe();
            mismatches = 0;
            checked    = 0;
            appends    = 0;
            drops      = 0;
            clears     = 0;
        endfunction

        function void wipe();
            foreach (counts[i])
            begin
                ids[i]    = '0;
                counts[i] = '0;
            end
            used    = 0;
            total   = '0;
            largest = '0;
        endfunction

        // Predict the result of one accepted word and queue it.
        function void note_word(logic kind, logic [IN_ID_W-1:0] word_id);
            result_t r;
            id_t     key;
            int      pos;
            r   = '0;
            pos = -1;
            if (kind == KIND_CLEAR)
            begin
                wipe();
                clears++;
            end
            else
            begin
                key = id_t'(word_id);
                for (int i = 0; i < used; i++)
                    if (pos < 0 && ids[i] == key)
                        pos = i;
                if (pos >= 0)
                begin
                    if (counts[pos] != COUNT_MAX)
                        counts[pos]++;
                end
                else if (used < MAX_CONTACTS)
                begin
                    pos         = used;
                    ids[pos]    = key;
                    counts[pos] = count_t'(1);
                    used++;
                    r.is_new = 1'b1;
                    appends++;
                end
                else
                begin
                    r.table_full = 1'b1;
                    drops++;
                end
                if (pos >= 0)
                begin
                    r.slot = idx_t'(pos);
                    if (counts[pos] > largest)
                        largest = counts[pos];
                end
                if (total != TOTAL_MAX)
                    total++;
            end
            r.unique_count   = used_t'(used);
            r.total_contacts = total;
            r.peak_count     = largest;
            expected_q.insert(expected_q.size(), r);
        endfunction

        // Compare one accepted result against the oldest prediction.
        function void check_result(result_t got);
            result_t exp;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result: slot=%0d new=%0b full=%0b %s",
                             $realtime, got.slot, got.is_new, got.table_full,
                             $sformatf("uniq=%0d total=%0d max=%0d", got.unique_count,
                                       got.total_contacts, got.peak_count));
                return;
            end
            exp = expected_q.pop_front();
            checked++;
            if (got.slot !== exp.slot || got.is_new !== exp.is_new
                || got.table_full !== exp.table_full
                || got.unique_count !== exp.unique_count
                || got.total_contacts !== exp.total_contacts
                || got.peak_count !== exp.peak_count)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("[%0t] result %0d mismatch", $realtime, checked);
                    $display("    expected slot=%0d new=%0b full=%0b uniq=%0d total=%0d max=%0d",
                             exp.slot, exp.is_new, exp.table_full,
                             exp.unique_count, exp.total_contacts, exp.peak_count);
                    $display("    actual   slot=%0d new=%0b full=%0b uniq=%0d total=%0d max=%0d",
                             got.slot, got.is_new, got.table_full,
                             got.unique_count, got.total_contacts, got.peak_count);
                end
            end
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    nctt_in_if  cmd_if ();
    nctt_out_if rsp_if ();

    neighbour_contact_tally_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    tally_scoreboard sb = new();

    // When set, both sides run back to back with no idle cycles.
    bit steady = 1'b0;
    int words_sent = 0;
    int cycles = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog: abort a run that hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("watchdog expired after %0d cycles, %0d results pending",
                     cycles, sb.outstanding());
            $display("** neighbour_contact_tally_table: FAILED **");
            $finish;
        end
    end

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 6);
    endfunction

    // Offer one word after a random idle gap and hold it until accepted.
    // All signals are sampled at the edge, before the block's own updates
    // land, so valid && ready seen here is exactly the handshake.
    task automatic send_word(input logic kind, input logic [IN_ID_W-1:0] word_id);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid        <= 1'b1;
        cmd_if.kind         <= kind;
        cmd_if.neighbour_id <= word_id;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        sb.note_word(kind, word_id);
        words_sent++;
    endtask

    // Result side: stall a random number of cycles per word, then take one.
    initial
    begin
        result_t got;
        int      gap;
        rsp_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_if.valid);
            got.slot           = rsp_if.slot;
            got.is_new         = rsp_if.is_new;
            got.table_full     = rsp_if.table_full;
            got.unique_count   = rsp_if.unique_count;
            got.total_contacts = rsp_if.total_contacts;
            got.peak_count     = rsp_if.peak_count;
            sb.check_result(got);
        end
    end

    // Stimulus.
    initial
    begin
        logic [IN_ID_W-1:0] pool [32];
        logic [IN_ID_W-1:0] sat_id;
        int pool_n;
        int span;
        int roll;
        int random_sent;

        rst_n               = 1'b0;
        cmd_if.valid        <= 1'b0;
        cmd_if.kind         <= KIND_ADD;
        cmd_if.neighbour_id <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme identifiers, hit and append, clear, then fill
        // all sixteen entries and push a new identifier into the full table.
        steady = 1'b0;
        send_word(KIND_ADD, 16'h0000);
        send_word(KIND_ADD, 16'hFFFF);
        send_word(KIND_ADD, 16'h0000);
        send_word(KIND_ADD, 16'hFFFF);
        send_word(KIND_CLEAR, 16'hA5A5);
        send_word(KIND_ADD, 16'hFFFF);
        for (int i = 1; i < MAX_CONTACTS; i++)
            send_word(KIND_ADD, 16'h8000 + 16'(i));
        send_word(KIND_ADD, 16'h7FFF);      // dropped: table full
        send_word(KIND_ADD, 16'h800F);      // hit on the last slot of a full table
        send_word(KIND_CLEAR, 16'h5A5A);

        // Saturation burst: one identifier repeated back to back until its
        // pair count pins at the ceiling.
        steady = 1'b1;
        sat_id = 16'($urandom);
        repeat (SAT_ADDS) send_word(KIND_ADD, sat_id);
        send_word(KIND_ADD, ~sat_id);
        send_word(KIND_CLEAR, 16'($urandom));

        // Random part: epochs that start from a clear and draw identifiers
        // from a small pool, so hits dominate; some pools exceed the table
        // and force drops. A few fresh identifiers and stray clears mix in.
        random_sent = 0;
        while (random_sent < RANDOM_WORDS)
        begin
            steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 4))
                0: pool_n = 4;
                1: pool_n = 12;
                2: pool_n = 16;
                3: pool_n = 20;
                default: pool_n = 28;
            endcase
            for (int k = 0; k < pool_n; k++)
                pool[k] = 16'($urandom);
            send_word(KIND_CLEAR, 16'($urandom));
            random_sent++;
            span = $urandom_range(20, 60);
            for (int k = 0; k < span && random_sent < RANDOM_WORDS; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 2)
                    send_word(KIND_CLEAR, 16'($urandom));
                else if (roll < 6)
                    send_word(KIND_ADD, 16'($urandom));
                else
                    send_word(KIND_ADD, pool[$urandom_range(0, pool_n - 1)]);
                random_sent++;
            end
        end
        cmd_if.valid <= 1'b0;

        // Drain: wait for every predicted result, then keep watching the result
        // side to catch any stray extra result.
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d words (%0d clears), checked %0d results", words_sent,
                 sb.clears, sb.checked);
        $display("table appends %0d, drops on a full table %0d, saturation burst %0d adds",
                 sb.appends, sb.drops, SAT_ADDS);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("** neighbour_contact_tally_table: PASSED **");
        else
        begin
            $display("%0d mismatches, %0d results never arrived", sb.mismatches,
                     sb.outstanding());
            $display("** neighbour_contact_tally_table: FAILED **");
        end
        $finish;
    end

endmodule
